FILE: src/bfa_pkg.sv
// Shared types, constants and helpers for the bitmap first-free allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int NUM_W  = 14;               // item number / limit width
  localparam int CNT_W  = 16;               // free counter width
  localparam int WORD_W = 32;               // bitmap word width
  localparam int WSEL_W = 5;                // bit select within a word
  localparam int SUM_SH = 2 * WSEL_W;       // bits covered by one summary word, log2

  localparam logic [NUM_W-1:0] BITS_IN_USE_RST = 14'd8192;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_CHK,
    ST_WORD_CHK,
    ST_MOD_RD,
    ST_MOD_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [NUM_W-1:0] number_res;
    logic             ok;
    logic [CNT_W-1:0] free_count;
  } res_t;

  // Lowest set bit: {found, index}
  function automatic logic [WSEL_W:0] first_set(input logic [WORD_W-1:0] v);
    logic [WSEL_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, WSEL_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

FILE: src/bfa_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bfa_engine.sv
// Request sequencer: clearing pass, two-level first-free search, bit set/clear.
`timescale 1ns / 1ps

module bfa_engine #(
  parameter int BITMAP_BYTES = 1024,
  localparam int MAP_BITS = BITMAP_BYTES * 8,
  localparam int WORDS = (MAP_BITS + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W,
  localparam int SUMS = (WORDS + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W,
  localparam int WA_W = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int SA_W = (SUMS > 1) ? $clog2(SUMS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bfa_pkg::op_t                in_op,
  input  logic [bfa_pkg::NUM_W-1:0]   in_num,
  input  logic [bfa_pkg::NUM_W-1:0]   bits_in_use,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bfa_pkg::res_t               res,
  output logic                        w_we,
  output logic [WA_W-1:0]             w_waddr,
  output logic [bfa_pkg::WORD_W-1:0]  w_wdata,
  output logic [WA_W-1:0]             w_raddr,
  input  logic [bfa_pkg::WORD_W-1:0]  w_rdata,
  output logic                        s_we,
  output logic [SA_W-1:0]             s_waddr,
  output logic [bfa_pkg::WORD_W-1:0]  s_wdata,
  output logic [SA_W-1:0]             s_raddr,
  input  logic [bfa_pkg::WORD_W-1:0]  s_rdata
);

  import bfa_pkg::*;

  localparam int BI_W = WA_W + WSEL_W;
  localparam int CW = ((NUM_W > BI_W) ? NUM_W : BI_W) + 1;
  localparam logic [CW-1:0] MAP_BITS_C = CW'(MAP_BITS);
  localparam logic [WA_W:0] SUMS_C = (WA_W + 1)'(SUMS);
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  cnt_free, cnt_free_next;
  logic [WA_W-1:0]   clr_cnt, clr_cnt_next;
  op_t               op_r, op_next;
  logic [NUM_W-1:0]  num_r, num_next;
  logic [SA_W:0]     s_cnt, s_cnt_next;
  logic [WSEL_W-1:0] k_r, k_next;
  logic [WA_W-1:0]   w_addr, w_addr_next;
  logic [WORD_W-1:0] sum_word, sum_word_next;
  res_t              res_r, res_next;

  // limit and search terms
  logic [CW-1:0]     bits_ext, lim, sbase, bnum, bnum_p1;
  logic [WORD_W-1:0] cand;
  logic [WSEL_W:0]   sfind, wfind;
  logic              alloc_hit;
  logic [WORD_W-1:0] alloc_word;
  logic [SA_W+WSEL_W-1:0] alloc_widx;

  // free / mark terms
  logic [CW-1:0]     num_ext, nm1, nm1_w, nm1_s;
  logic              in_map;
  logic [WSEL_W-1:0] m_k, m_j;
  logic [WORD_W-1:0] m_mask, m_word, m_sum;

  always_comb begin
    bits_ext = CW'(bits_in_use);
    lim = (bits_ext < MAP_BITS_C) ? bits_ext : MAP_BITS_C;
    sbase = CW'(s_cnt) << SUM_SH;
    for (int k = 0; k < WORD_W; k++) begin
      cand[k] = !s_rdata[k] && ((sbase + (CW'(k) << WSEL_W)) < lim);
    end
    sfind = first_set(cand);
    alloc_widx = {s_cnt[SA_W-1:0], sfind[WSEL_W-1:0]};
    wfind = first_set(~w_rdata);
    bnum = CW'({s_cnt[SA_W-1:0], k_r, wfind[WSEL_W-1:0]});
    bnum_p1 = bnum + CW'(1);
    alloc_hit = wfind[WSEL_W] && (bnum < lim);
    alloc_word = w_rdata | (WORD_W'(1) << wfind[WSEL_W-1:0]);

    num_ext = CW'(num_r);
    nm1 = num_ext - CW'(1);
    nm1_w = nm1 >> WSEL_W;
    nm1_s = nm1 >> SUM_SH;
    in_map = (num_r != '0) && (num_ext <= MAP_BITS_C);
    m_k = nm1_w[WSEL_W-1:0];
    m_j = nm1[WSEL_W-1:0];
    m_mask = WORD_W'(1) << m_j;
    m_word = (op_r == OP_FREE) ? (w_rdata & ~m_mask) : (w_rdata | m_mask);
    m_sum = s_rdata;
    m_sum[m_k] = &m_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      cnt_free <= '0;
      clr_cnt  <= '0;
    end else begin
      state    <= state_next;
      cnt_free <= cnt_free_next;
      clr_cnt  <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_next;
    num_r    <= num_next;
    s_cnt    <= s_cnt_next;
    k_r      <= k_next;
    w_addr   <= w_addr_next;
    sum_word <= sum_word_next;
    res_r    <= res_next;
  end

  always_comb begin
    state_next    = state;
    cnt_free_next = cnt_free;
    clr_cnt_next  = clr_cnt;
    op_next       = op_r;
    num_next      = num_r;
    s_cnt_next    = s_cnt;
    k_next        = k_r;
    w_addr_next   = w_addr;
    sum_word_next = sum_word;
    res_next      = res_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    w_we          = 1'b0;
    w_waddr       = w_addr;
    w_wdata       = alloc_word;
    w_raddr       = nm1_w[WA_W-1:0];
    s_we          = 1'b0;
    s_waddr       = s_cnt[SA_W-1:0];
    s_wdata       = sum_word | (WORD_W'(1) << k_r);
    s_raddr       = s_cnt[SA_W-1:0];

    case (state)
      ST_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_cnt;
        w_wdata = '0;
        s_we    = ({1'b0, clr_cnt} < SUMS_C);
        s_waddr = clr_cnt[SA_W-1:0];
        s_wdata = '0;
        clr_cnt_next = clr_cnt + WA_W'(1);
        if (clr_cnt == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next    = in_op;
          num_next   = in_num;
          s_cnt_next = '0;
          case (in_op)
            OP_ALLOC: state_next = ST_SUM_RD;
            OP_FREE, OP_MARK: state_next = ST_MOD_RD;
            default: begin
              res_next   = '{number_res: in_num, ok: 1'b0, free_count: cnt_free};
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_SUM_RD: begin
        if (sbase >= lim) begin
          res_next   = '{number_res: '0, ok: 1'b0, free_count: cnt_free};
          state_next = ST_DONE;
        end else begin
          state_next = ST_SUM_CHK;
        end
      end
      ST_SUM_CHK: begin
        w_raddr = alloc_widx[WA_W-1:0];
        if (sfind[WSEL_W]) begin
          k_next        = sfind[WSEL_W-1:0];
          w_addr_next   = alloc_widx[WA_W-1:0];
          sum_word_next = s_rdata;
          state_next    = ST_WORD_CHK;
        end else begin
          s_cnt_next = s_cnt + (SA_W + 1)'(1);
          state_next = ST_SUM_RD;
        end
      end
      ST_WORD_CHK: begin
        if (alloc_hit) begin
          w_we          = 1'b1;
          s_we          = &alloc_word;
          cnt_free_next = cnt_free - CNT_W'(1);
          res_next      = '{number_res: bnum_p1[NUM_W-1:0], ok: 1'b1,
                            free_count: cnt_free - CNT_W'(1)};
        end else begin
          res_next = '{number_res: '0, ok: 1'b0, free_count: cnt_free};
        end
        state_next = ST_DONE;
      end
      ST_MOD_RD: begin
        s_raddr = nm1_s[SA_W-1:0];
        if (in_map) begin
          state_next = ST_MOD_WR;
        end else begin
          if (op_r == OP_FREE) begin
            cnt_free_next = cnt_free + CNT_W'(1);
          end
          res_next   = '{number_res: num_r, ok: 1'b0, free_count: cnt_free_next};
          state_next = ST_DONE;
        end
      end
      ST_MOD_WR: begin
        w_we    = 1'b1;
        w_waddr = nm1_w[WA_W-1:0];
        w_wdata = m_word;
        s_we    = 1'b1;
        s_waddr = nm1_s[SA_W-1:0];
        s_wdata = m_sum;
        if (op_r == OP_FREE) begin
          cnt_free_next = cnt_free + CNT_W'(1);
        end
        res_next   = '{number_res: num_r, ok: 1'b1, free_count: cnt_free_next};
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign res = res_r;

  // on allocation, a summary bit is only set for a word that has just become full
  a_sum_set_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WORD_CHK && s_we) |-> &w_wdata)
    else $error("summary marked full for a word with a clear bit");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WORD_CHK && alloc_hit) |=> (cnt_free == $past(cnt_free) - CNT_W'(1)))
    else $error("free counter not decremented on allocation");

  a_alloc_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_r.ok && op_r == OP_ALLOC) |-> (res_r.number_res != '0))
    else $error("successful allocation returned number zero");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (w_we || s_we || res_valid) |-> !in_ready)
    else $error("item accepted while the map is being written or a result waits");

endmodule

FILE: src/bitmap_first_free_allocator_top.sv
// Top level of the bitmap first-free allocator: config register, memories, result register.
`timescale 1ns / 1ps

// Bitmap allocator with a first-free search and a 16-bit free counter.
// Request channel (s_*): s_tuser carries the operation (alloc, free, mark_used),
// s_tdata the 1-based item number. One result item comes back on m_* per request:
// m_tdata holds the number (allocated, or echoed) and the free counter,
// m_tuser is the ok flag.
// The map sits in a word memory (32 bits per word) with a summary memory holding
// one "word full" bit per word; both are read-modify-write with registered reads.
// Items are handled one at a time. Free and mark_used read the bitmap word and its
// summary word, then write both back; an unused operation code goes straight to the
// result. Alloc scans summary words in turn (at most ceil(BITMAP_BYTES / 128), so 8 at
// the default size), then checks the chosen bitmap word and sets its first clear bit.
// Reset (rst, synchronous) empties the map, zeroes the counter and sets
// bits_in_use to 8192, then runs a clearing pass over the ceil(BITMAP_BYTES / 4)
// bitmap words (256 at the default size); s_tready stays low meanwhile.
// cfg_we/cfg_wdata write bits_in_use at any edge; write it only while idle.
// A finished result waits in the output register while m_tready is low; the
// next request can be accepted and worked on, and it holds until that slot frees.
module bitmap_first_free_allocator_top #(
  parameter int BITMAP_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [13:0] number, [15:14] zero
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [13:0] number_res, [29:14] free_count, [31:30] zero
  output logic        m_tuser,   // [0] ok
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata  // bits_in_use
);

  import bfa_pkg::*;

  localparam int MAP_BITS = BITMAP_BYTES * 8;
  localparam int WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int SUMS = (WORDS + WORD_W - 1) / WORD_W;
  localparam int WA_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SA_W = (SUMS > 1) ? $clog2(SUMS) : 1;

  logic [NUM_W-1:0] bits_in_use;

  logic              res_valid, res_ready;
  res_t              res, out_r;

  logic              w_we, s_we;
  logic [WA_W-1:0]   w_waddr, w_raddr;
  logic [SA_W-1:0]   s_waddr, s_raddr;
  logic [WORD_W-1:0] w_wdata, w_rdata, s_wdata, s_rdata;

  // search limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_in_use <= BITS_IN_USE_RST;
    end else if (cfg_we) begin
      bits_in_use <= cfg_wdata;
    end
  end

  bfa_engine #(.BITMAP_BYTES(BITMAP_BYTES)) u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (op_t'(s_tuser)),
    .in_num      (s_tdata[NUM_W-1:0]),
    .bits_in_use (bits_in_use),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .w_we        (w_we),
    .w_waddr     (w_waddr),
    .w_wdata     (w_wdata),
    .w_raddr     (w_raddr),
    .w_rdata     (w_rdata),
    .s_we        (s_we),
    .s_waddr     (s_waddr),
    .s_wdata     (s_wdata),
    .s_raddr     (s_raddr),
    .s_rdata     (s_rdata)
  );

  // bitmap words
  bfa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_map_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // one "word full" bit per bitmap word
  bfa_ram #(.WIDTH(WORD_W), .DEPTH(SUMS)) u_sum_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_tdata = {2'b00, out_r.free_count, out_r.number_res};
  assign m_tuser = out_r.ok;

endmodule
